// ===== src/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpa_pkg
// Types and fixed widths shared by the bitmap page allocator modules.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int PAGE_W    = 18;   // internal page positions, room for pos + len
    localparam int TOTAL_W   = 17;   // page total and search hint
    localparam int LEN_W     = 9;
    localparam int START_W   = 16;
    localparam int FIRST_W   = 16;
    localparam int WORD_BITS = 64;   // pages per bitmap word
    localparam int OFS_W     = 6;    // bit offset inside a word
    localparam int SPAN_W    = 7;    // 0..64 bit counts inside a word

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_MOD_RD,
        ST_MOD_WR,
        ST_FINISH
    } bpa_state_t;

    typedef struct packed {
        logic               operation;
        logic [LEN_W-1:0]   run_length;
        logic [START_W-1:0] start_page;
    } bpa_req_t;

    typedef struct packed {
        logic [FIRST_W-1:0] alloc_page;
        logic               out_of_memory;
    } bpa_res_t;

endpackage

// ===== src/bpa_ram.sv =====
// ----------------------------------------------------------------------------
// bpa_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bpa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/bpa_engine.sv =====
// ----------------------------------------------------------------------------
// bpa_engine
// Sequencer for the allocator: fills the bitmap with ones after reset, scans
// bitmap words for a free run, and read-modify-writes runs of bits to mark them used or free.
// ----------------------------------------------------------------------------
module bpa_engine import bpa_pkg::*; #(
    parameter int MAX_RUN   = 256,
    parameter int DEPTH     = 1024,
    parameter int AW        = 10
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 req_valid,
    input  bpa_req_t             req,
    output logic                 req_ready,
    input  logic [TOTAL_W-1:0]   lim,
    output logic                 res_valid,
    output bpa_res_t             res,
    input  logic                 res_ready,
    output logic                 mem_we,
    output logic [AW-1:0]        mem_waddr,
    output logic [WORD_BITS-1:0] mem_wdata,
    output logic [AW-1:0]        mem_raddr,
    input  logic [WORD_BITS-1:0] mem_rdata
);

    function automatic logic [AW-1:0] word_addr(input logic [PAGE_W-1:0] p);
        logic [31:0] w;
        w = 32'(p >> OFS_W);
        return w[AW-1:0];
    endfunction

    // Bits lo up to hi-1 of one word; hi may be the full word width.
    function automatic logic [WORD_BITS-1:0] word_mask(input logic [SPAN_W-1:0] lo,
                                                       input logic [SPAN_W-1:0] hi);
        logic [WORD_BITS:0]   up;
        logic [WORD_BITS-1:0] dn;
        up = ((WORD_BITS+1)'(1) << hi) - (WORD_BITS+1)'(1);
        dn = ~((WORD_BITS'(1) << lo) - WORD_BITS'(1));
        return up[WORD_BITS-1:0] & dn;
    endfunction

    function automatic logic [OFS_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
        logic [OFS_W-1:0] r;
        r = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = OFS_W'(i);
            end
        end
        return r;
    endfunction

    bpa_state_t          state_reg, state_next;
    logic [PAGE_W-1:0]   pos_reg, pos_next;
    logic [PAGE_W-1:0]   cur_reg, cur_next;
    logic [LEN_W-1:0]    cnt_reg, cnt_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic                wrapped_reg, wrapped_next;
    logic [TOTAL_W-1:0]  hint_reg, hint_next;
    logic [PAGE_W-1:0]   mod_hi_reg, mod_hi_next;
    logic                mod_set_reg, mod_set_next;
    logic [AW-1:0]       clr_reg, clr_next;
    logic [FIRST_W-1:0]  res_first_reg, res_first_next;
    logic                res_oom_reg, res_oom_next;

    // Request decode.
    logic [LEN_W-1:0]    free_len;
    logic [PAGE_W-1:0]   free_sum;
    logic [PAGE_W-1:0]   free_end;
    logic                free_any;
    logic                alloc_bad;

    // Scan and modify datapath.
    logic [OFS_W-1:0]     ofs;
    logic [SPAN_W-1:0]    avail;
    logic [LEN_W-1:0]     need;
    logic [SPAN_W-1:0]    take;
    logic [WORD_BITS-1:0] hits;
    logic                 blocked;
    logic [OFS_W-1:0]     hit_bit;
    logic [LEN_W-1:0]     cnt_sum;
    logic                 scan_done;
    logic [PAGE_W-1:0]    base;
    logic [PAGE_W-1:0]    next_base;
    logic [PAGE_W-1:0]    pos_end;
    logic                 check_fail;
    logic [PAGE_W-1:0]    mod_rem;
    logic [SPAN_W-1:0]    mod_hi7;
    logic [WORD_BITS-1:0] mod_mask;
    logic [WORD_BITS-1:0] wr_word;

    always_comb begin
        free_len  = (32'(req.run_length) > MAX_RUN) ? LEN_W'(MAX_RUN) : req.run_length;
        free_sum  = PAGE_W'(req.start_page) + PAGE_W'(free_len);
        free_end  = (free_sum < PAGE_W'(lim)) ? free_sum : PAGE_W'(lim);
        free_any  = free_end > PAGE_W'(req.start_page);
        alloc_bad = (req.run_length == '0) || (32'(req.run_length) > MAX_RUN);

        ofs       = cur_reg[OFS_W-1:0];
        avail     = SPAN_W'(WORD_BITS) - SPAN_W'(ofs);
        need      = len_reg - cnt_reg;
        take      = (need < LEN_W'(avail)) ? SPAN_W'(need) : avail;
        hits      = mem_rdata & word_mask(SPAN_W'(ofs), SPAN_W'(ofs) + take);
        blocked   = |hits;
        hit_bit   = lowest_set(hits);
        cnt_sum   = cnt_reg + LEN_W'(take);
        scan_done = (cnt_sum == len_reg);

        base       = {cur_reg[PAGE_W-1:OFS_W], {OFS_W{1'b0}}};
        next_base  = base + PAGE_W'(WORD_BITS);
        pos_end    = pos_reg + PAGE_W'(len_reg);
        // A candidate run must end at or below the page total.
        check_fail = pos_end > PAGE_W'(lim);

        mod_rem  = mod_hi_reg - base;
        mod_hi7  = (mod_rem >= PAGE_W'(WORD_BITS)) ? SPAN_W'(WORD_BITS) : SPAN_W'(mod_rem);
        mod_mask = word_mask(SPAN_W'(ofs), mod_hi7);
        wr_word  = mod_set_reg ? (mem_rdata | mod_mask) : (mem_rdata & ~mod_mask);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (req_valid) begin
                    if (req.operation == OP_FREE) begin
                        state_next = free_any ? ST_MOD_RD : ST_FINISH;
                    end else begin
                        state_next = alloc_bad ? ST_FINISH : ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (check_fail) begin
                    state_next = wrapped_reg ? ST_FINISH : ST_CHECK;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (blocked) begin
                    state_next = ST_CHECK;
                end else if (scan_done) begin
                    state_next = ST_MOD_RD;
                end
            end
            ST_MOD_RD: state_next = ST_MOD_WR;
            ST_MOD_WR: begin
                if (next_base >= mod_hi_reg) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_MOD_RD;
                end
            end
            ST_FINISH: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        pos_next       = pos_reg;
        cur_next       = cur_reg;
        cnt_next       = cnt_reg;
        len_next       = len_reg;
        wrapped_next   = wrapped_reg;
        hint_next      = hint_reg;
        mod_hi_next    = mod_hi_reg;
        mod_set_next   = mod_set_reg;
        clr_next       = clr_reg;
        res_first_next = res_first_reg;
        res_oom_next   = res_oom_reg;
        mem_we         = 1'b0;
        mem_waddr      = word_addr(cur_reg);
        mem_wdata      = wr_word;
        mem_raddr      = word_addr(cur_reg);
        req_ready      = 1'b0;
        res_valid      = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '1;
                clr_next  = clr_reg + AW'(1);
            end
            ST_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    res_first_next = '0;
                    res_oom_next   = 1'b0;
                    if (req.operation == OP_FREE) begin
                        cur_next     = PAGE_W'(req.start_page);
                        mod_hi_next  = free_end;
                        mod_set_next = 1'b0;
                    end else if (alloc_bad) begin
                        res_oom_next = 1'b1;
                    end else begin
                        pos_next     = PAGE_W'(hint_reg);
                        cur_next     = PAGE_W'(hint_reg);
                        cnt_next     = '0;
                        wrapped_next = 1'b0;
                        len_next     = req.run_length;
                    end
                end
            end
            ST_CHECK: begin
                if (check_fail) begin
                    if (wrapped_reg) begin
                        res_oom_next = 1'b1;
                    end else begin
                        pos_next     = '0;
                        cur_next     = '0;
                        cnt_next     = '0;
                        wrapped_next = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                if (blocked) begin
                    // Next candidate starts just past the first used page.
                    pos_next = base + PAGE_W'(hit_bit) + PAGE_W'(1);
                    cur_next = base + PAGE_W'(hit_bit) + PAGE_W'(1);
                    cnt_next = '0;
                end else if (scan_done) begin
                    hint_next      = pos_end[TOTAL_W-1:0];
                    res_first_next = pos_reg[FIRST_W-1:0];
                    mod_hi_next    = pos_end;
                    mod_set_next   = 1'b1;
                    cur_next       = pos_reg;
                end else begin
                    cnt_next  = cnt_sum;
                    cur_next  = cur_reg + PAGE_W'(take);
                    mem_raddr = word_addr(cur_reg + PAGE_W'(take));
                end
            end
            ST_MOD_RD: begin
            end
            ST_MOD_WR: begin
                mem_we   = 1'b1;
                cur_next = next_base;
            end
            ST_FINISH: begin
                res_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            hint_reg    <= '0;
            wrapped_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            hint_reg    <= hint_next;
            wrapped_reg <= wrapped_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg       <= pos_next;
        cur_reg       <= cur_next;
        cnt_reg       <= cnt_next;
        len_reg       <= len_next;
        mod_hi_reg    <= mod_hi_next;
        mod_set_reg   <= mod_set_next;
        res_first_reg <= res_first_next;
        res_oom_reg   <= res_oom_next;
    end

    assign res.alloc_page    = res_first_reg;
    assign res.out_of_memory = res_oom_reg;

endmodule

// ===== src/bitmap_page_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// Next-fit page allocator over a used-page bitmap held in a RAM.
// ----------------------------------------------------------------------------
// The bitmap is kept in a RAM of 64-bit words, one bit per page, with one
// read and one write port; every scan and modify step goes through that
// read port. After reset the block fills the whole bitmap with ones, one
// word per cycle, and keeps s_ready low until all ceil(MAX_PAGES/64) words
// (1024 at the default) are written; configuration writes are taken during
// that time. A free reads and then writes back each bitmap word the run
// touches (at most 5 for runs of 256 pages) before its result is ready. An
// allocate checks each candidate start position and examines the bitmap
// words for that candidate, then reads and writes back each word it marks
// used before its result is ready. A new item is accepted while the
// previous result still waits on m_valid.
module bitmap_page_allocator import bpa_pkg::*; #(
    parameter int MAX_PAGES = 65536,
    parameter int MAX_RUN   = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [TOTAL_W-1:0]  cfg_total_pages,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_operation,
    input  logic [LEN_W-1:0]    s_run_length,
    input  logic [START_W-1:0]  s_start_page,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [FIRST_W-1:0]  m_alloc_page,
    output logic                m_out_of_memory
);

    localparam int DEPTH = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [31:0] MAX_PAGES_W = 32'(MAX_PAGES);

    logic [TOTAL_W-1:0]  total_pages_reg;
    logic [TOTAL_W-1:0]  lim;
    logic                m_valid_reg;
    logic [FIRST_W-1:0]  m_alloc_page_reg;
    logic                m_oom_reg;

    bpa_req_t             req;
    bpa_res_t             res;
    logic                 res_valid;
    logic                 res_ready;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [AW-1:0]        mem_raddr;
    logic [WORD_BITS-1:0] mem_rdata;

    assign cfg_ready = 1'b1;
    assign lim = (32'(total_pages_reg) > MAX_PAGES_W) ? MAX_PAGES_W[TOTAL_W-1:0]
                                                      : total_pages_reg;

    assign req.operation  = s_operation;
    assign req.run_length = s_run_length;
    assign req.start_page = s_start_page;

    // The result register frees up in the same cycle its item is taken.
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_pages_reg <= TOTAL_W'(65536);
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                total_pages_reg <= cfg_total_pages;
            end
            if (res_valid && res_ready) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_alloc_page_reg <= res.alloc_page;
            m_oom_reg        <= res.out_of_memory;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_alloc_page    = m_alloc_page_reg;
    assign m_out_of_memory = m_oom_reg;

    bpa_engine #(
        .MAX_RUN   (MAX_RUN),
        .DEPTH     (DEPTH),
        .AW        (AW)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_valid),
        .req       (req),
        .req_ready (s_ready),
        .lim       (lim),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    bpa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_map_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the next-fit bitmap page allocator. A predictor
// keeps its own used-page map, search hint and page total, and works out the
// reply to every accepted request. Directed tests cover the page total
// extremes, the wrap of the search, the run length limits and the free
// bounds. Random traffic then allocates and frees runs under several
// handshake idle and stall settings.
// ----------------------------------------------------------------------------
module testbench import bpa_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAP_PAGES = 65536;
    localparam int RUN_LIMIT = 256;

    typedef struct {
        int first;
        int len;
    } page_run_t;

    logic               aclk            = 1'b0;
    logic               aresetn         = 1'b0;
    logic               cfg_valid       = 1'b0;
    logic               cfg_ready;
    logic [TOTAL_W-1:0] cfg_total_pages = '0;
    logic               s_valid         = 1'b0;
    logic               s_ready;
    logic               s_operation     = OP_ALLOC;
    logic [LEN_W-1:0]   s_run_length    = '0;
    logic [START_W-1:0] s_start_page    = '0;
    logic               m_valid;
    logic               m_ready         = 1'b0;
    logic [FIRST_W-1:0] m_alloc_page;
    logic               m_out_of_memory;

    // Predictor state.
    bit        page_busy [MAP_PAGES];
    int        next_fit_hint = 0;
    int        page_total    = 65536;
    bpa_res_t  reply_queue [$];
    page_run_t live_runs [$];

    int fail_count     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    bitmap_page_allocator #(
        .MAX_PAGES (MAP_PAGES),
        .MAX_RUN   (RUN_LIMIT)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_total_pages (cfg_total_pages),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_run_length    (s_run_length),
        .s_start_page    (s_start_page),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_alloc_page    (m_alloc_page),
        .m_out_of_memory (m_out_of_memory)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic int usable_pages();
        return (page_total > MAP_PAGES) ? MAP_PAGES : page_total;
    endfunction

    // Works out the reply to one request and updates the map and the hint.
    function automatic bpa_res_t serve_request(logic op, logic [LEN_W-1:0] len_in,
                                               logic [START_W-1:0] start);
        int       lim;
        int       len;
        int       pos;
        int       k;
        bit       wrapped;
        bit       done;
        bpa_res_t reply;
        lim   = usable_pages();
        len   = int'(len_in);
        reply = '0;
        if (op == OP_FREE) begin
            if (len > RUN_LIMIT) len = RUN_LIMIT;
            for (k = 0; k < len; k++) begin
                if (int'(start) + k < lim) page_busy[int'(start) + k] = 1'b0;
            end
        end else if (len == 0 || len > RUN_LIMIT) begin
            reply.out_of_memory = 1'b1;
        end else begin
            pos     = next_fit_hint;
            wrapped = 1'b0;
            done    = 1'b0;
            while (!done) begin
                if (pos > lim || lim - pos < len) begin
                    if (wrapped) begin
                        reply.out_of_memory = 1'b1;
                        done = 1'b1;
                    end else begin
                        wrapped = 1'b1;
                        pos     = 0;
                    end
                end else begin
                    k = 0;
                    while (k < len && !page_busy[pos + k]) k++;
                    if (k < len) begin
                        pos = pos + k + 1;
                    end else begin
                        for (k = 0; k < len; k++) page_busy[pos + k] = 1'b1;
                        next_fit_hint    = (pos + len) & 32'h1FFFF;
                        reply.alloc_page = pos[FIRST_W-1:0];
                        done = 1'b1;
                    end
                end
            end
        end
        return reply;
    endfunction

    // Sends one item, predicts its reply at acceptance, then idles at random.
    task automatic issue_request(input logic op, input logic [LEN_W-1:0] len,
                                 input logic [START_W-1:0] start);
        bpa_res_t  reply;
        page_run_t run;
        int        gap;
        s_valid      <= 1'b1;
        s_operation  <= op;
        s_run_length <= len;
        s_start_page <= start;
        do @(posedge aclk); while (s_ready !== 1'b1);
        reply = serve_request(op, len, start);
        reply_queue.push_back(reply);
        if (op == OP_ALLOC && !reply.out_of_memory) begin
            run.first = int'(reply.alloc_page);
            run.len   = int'(len);
            live_runs.push_back(run);
        end
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain_replies();
        s_valid <= 1'b0;
        while (reply_queue.size() != 0) @(posedge aclk);
    endtask

    // Only called while no request is in flight.
    task automatic write_total(input logic [TOTAL_W-1:0] value);
        cfg_valid       <= 1'b1;
        cfg_total_pages <= value;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        page_total = value;
        cfg_valid <= 1'b0;
    endtask

    always @(posedge aclk) begin : check_replies
        bpa_res_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (reply_queue.size() == 0) begin
                $error("reply with no request pending: alloc_page %0d, out_of_memory %0b",
                       m_alloc_page, m_out_of_memory);
                fail_count++;
            end else begin
                want = reply_queue.pop_front();
                if (m_alloc_page !== want.alloc_page) begin
                    $error("alloc_page: expected %0d, actual %0d",
                           want.alloc_page, m_alloc_page);
                    fail_count++;
                end
                if (m_out_of_memory !== want.out_of_memory) begin
                    $error("out_of_memory: expected %0b, actual %0b",
                           want.out_of_memory, m_out_of_memory);
                    fail_count++;
                end
            end
        end
    end

    // A total of zero manages nothing, and a total of one page wraps at once.
    task automatic test_empty_and_tiny_totals();
        write_total(17'd0);
        issue_request(OP_ALLOC, 9'd1, 16'd0);
        issue_request(OP_FREE, 9'd5, 16'd0);
        issue_request(OP_ALLOC, 9'd0, 16'd0);
        drain_replies();
        write_total(17'd1);
        issue_request(OP_ALLOC, 9'd1, 16'd0);
        issue_request(OP_FREE, 9'd1, 16'd0);
        issue_request(OP_ALLOC, 9'd1, 16'hFFFF);
        issue_request(OP_ALLOC, 9'd1, 16'd0);
        drain_replies();
    endtask

    // One long scan reaches the top of the map; the next request wraps to page 0.
    task automatic test_full_range_and_wrap();
        write_total(17'd65536);
        issue_request(OP_FREE, 9'd256, 16'd0);
        issue_request(OP_FREE, 9'd256, 16'd65280);
        issue_request(OP_ALLOC, 9'd256, 16'd0);
        issue_request(OP_ALLOC, 9'd256, 16'd0);
        drain_replies();
        // The largest register value is limited to the map size.
        write_total(17'h1FFFF);
        issue_request(OP_FREE, 9'd8, 16'd300);
        issue_request(OP_ALLOC, 9'd8, 16'd0);
        issue_request(OP_ALLOC, 9'd300, 16'd0);
        issue_request(OP_ALLOC, 9'd511, 16'hFFFF);
        drain_replies();
    endtask

    task automatic test_free_bounds_and_hint();
        write_total(17'd512);
        issue_request(OP_FREE, 9'd256, 16'd0);
        // Lengths above the run limit are clipped, and pages past the total
        // are left alone even when the run already covers free pages.
        issue_request(OP_FREE, 9'd300, 16'd256);
        issue_request(OP_FREE, 9'd100, 16'd500);
        issue_request(OP_FREE, 9'd0, 16'd0);
        issue_request(OP_ALLOC, 9'd200, 16'd0);
        issue_request(OP_ALLOC, 9'd8, 16'd0);
        issue_request(OP_ALLOC, 9'd250, 16'd0);
        issue_request(OP_FREE, 9'd4, 16'd100);
        drain_replies();
        // The hint now lies beyond the new total, so the scan starts at page 0.
        write_total(17'd200);
        issue_request(OP_ALLOC, 9'd4, 16'd0);
        issue_request(OP_ALLOC, 9'd1, 16'd0);
        drain_replies();
    endtask

    // Called only after the previous test has drained its replies.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int total);
        int lim;
        int p;
        int n;
        int pick;
        int len;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        write_total(total[TOTAL_W-1:0]);
        lim = usable_pages();
        for (p = 0; p < lim; p += RUN_LIMIT) begin
            issue_request(OP_FREE, LEN_W'(RUN_LIMIT), START_W'(p));
        end
        live_runs.delete();
        for (n = 0; n < 450; n++) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                issue_request($urandom_range(1) ? OP_FREE : OP_ALLOC,
                              LEN_W'($urandom_range(511)),
                              START_W'($urandom_range(1) ? $urandom_range(65535)
                                                         : $urandom_range(lim)));
            end else if (pick < 50 && live_runs.size() != 0) begin
                p = $urandom_range(live_runs.size() - 1);
                issue_request(OP_FREE, LEN_W'(live_runs[p].len),
                              START_W'(live_runs[p].first));
                live_runs.delete(p);
            end else begin
                pick = $urandom_range(99);
                if (pick < 70) len = $urandom_range(8, 1);
                else if (pick < 90) len = $urandom_range(64, 9);
                else len = $urandom_range(RUN_LIMIT, 65);
                issue_request(OP_ALLOC, LEN_W'(len), START_W'($urandom_range(65535)));
            end
        end
        drain_replies();
    endtask

    initial begin
        foreach (page_busy[i]) page_busy[i] = 1'b1;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_and_tiny_totals();
        test_full_range_and_wrap();
        test_free_bounds_and_hint();
        test_random_traffic(0, 0, 64);
        test_random_traffic(47, 0, $urandom_range(512, 65));
        test_random_traffic(0, 47, $urandom_range(512, 65));
        test_random_traffic(31, 31, 512);
        repeat (64) @(posedge aclk);
        if (fail_count == 0) begin
            $display("** bitmap_page_allocator: PASSED **");
        end else begin
            $display("** bitmap_page_allocator: FAILED **");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("** bitmap_page_allocator: FAILED **");
        $finish;
    end

endmodule
